>>> design/sorted_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Implication checked at every edge outside reset.
`define SPQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Capacity, counter width, entry layout and control codes shared by the queue and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic {
      REQ_PUSH = 1'b0,
      REQ_POP  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_FROM_PREV = 2'd1,
      CELL_FROM_NEXT = 2'd2,
      CELL_LOAD      = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic signed [31:0] price;
      logic signed [31:0] code;
   } entry_type;

endpackage

`default_nettype wire

>>> design/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry, compares it with the incoming key, and takes its next
// entry from itself, a neighbor or the incoming item.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
   input  wire                    clock,
   input  wire                    head_cell,
   input  spq_pkg::cell_op_type   ctrl_i,
   input  spq_pkg::entry_type     new_i,
   input  spq_pkg::entry_type     prev_i,
   input  spq_pkg::entry_type     next_i,
   output spq_pkg::entry_type     entry_o,
   output logic                   flag_o
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      key_lt_new;
   logic      key_eq_new;

   // The head cell displaces its entry only on a strictly smaller key; every
   // later cell does so as soon as its key is not below the new one.
   assign key_lt_new = entry_ff.price < new_i.price;
   assign key_eq_new = entry_ff.price == new_i.price;
   assign flag_o     = head_cell ? (!key_lt_new && !key_eq_new) : !key_lt_new;

   always_comb begin
      unique case (ctrl_i)
         CELL_HOLD:      entry_in = entry_ff;
         CELL_FROM_PREV: entry_in = prev_i;
         CELL_FROM_NEXT: entry_in = next_i;
         CELL_LOAD:      entry_in = new_i;
         default:        entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_o = entry_ff;

endmodule

`default_nettype wire

>>> design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Minimum-first queue of price-keyed entries held in ascending order in a
// row of cells; each beat pushes or pops and reports the head and count.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Ports
//   req      in         req_valid, req_ready, req_type, req_item_code,
//                       req_item_price
//   rsp      out        rsp_valid, rsp_ready, rsp_head_code, rsp_is_empty,
//                       rsp_entry_count, rsp_push_rejected
//
// One request beat is taken per cycle: all cells compare against the new key
// at once, so the insert or shift completes in the accepting cycle.
// The response beat appears in the cycle after its request and reflects the
// queue state directly, so no separate result storage is needed.
// While a response waits on rsp_ready the request side stalls; it reopens in
// the same cycle the waiting response is taken.
// Reset (synchronous, active high) empties the queue; cell contents are not
// cleared, since only cells below the fill count are ever observed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire                           req_type,
   input  wire  signed [31:0]            req_item_code,
   input  wire  signed [31:0]            req_item_price,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic signed [31:0]            rsp_head_code,
   output logic                          rsp_is_empty,
   output logic [4:0]                    rsp_entry_count,
   output logic                          rsp_push_rejected
);
   import spq_pkg::*;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rejected_ff;
   logic               rejected_in;
   logic [CNT_W+4:0]   count_ext;

   logic               accept;
   logic               is_push;
   logic               is_full;
   logic               push_ok;
   logic               pop_ok;

   entry_type          new_entry;
   entry_type          cell_entry [CAPACITY];
   cell_op_type        cell_ctrl  [CAPACITY];
   logic [CAPACITY-1:0] cell_shift;

   // The request side is open whenever the response register is free or is
   // being emptied in this same cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_push   = (req_type == REQ_PUSH);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign push_ok   = accept && is_push && !is_full;
   assign pop_ok    = accept && !is_push && (count_ff != '0);

   assign new_entry.price = req_item_price;
   assign new_entry.code  = req_item_code;

   // Each cell decides its own move from its flag and its left neighbor's.
   // Flags form a contiguous run from the insertion point to the last
   // occupied cell: that run shifts right by one, the first cell of the run
   // loads the new entry, and when the run is empty the first free cell does.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      occupied;
      logic      is_tail;
      logic      flag_raw;
      logic      prev_shift;
      entry_type prev_entry;
      entry_type next_entry;

      assign occupied     = CNT_W'(i) < count_ff;
      assign is_tail      = count_ff == CNT_W'(i);
      assign cell_shift[i] = occupied && flag_raw;

      if (i == 0) begin : g_first
         assign prev_shift = 1'b0;
         assign prev_entry = new_entry;
      end else begin : g_inner
         assign prev_shift = cell_shift[i-1];
         assign prev_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_body
         assign next_entry = cell_entry[i+1];
      end

      always_comb begin
         if (push_ok) begin
            if (prev_shift) begin
               cell_ctrl[i] = CELL_FROM_PREV;
            end else if (cell_shift[i] || is_tail) begin
               cell_ctrl[i] = CELL_LOAD;
            end else begin
               cell_ctrl[i] = CELL_HOLD;
            end
         end else if (pop_ok) begin
            cell_ctrl[i] = CELL_FROM_NEXT;
         end else begin
            cell_ctrl[i] = CELL_HOLD;
         end
      end

      spq_cell u_cell (
         .clock     (clock),
         .head_cell (i == 0),
         .ctrl_i    (cell_ctrl[i]),
         .new_i     (new_entry),
         .prev_i    (prev_entry),
         .next_i    (next_entry),
         .entry_o   (cell_entry[i]),
         .flag_o    (flag_raw)
      );
   end

   // Fill count and response bookkeeping.
   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // A rejected push is only possible on a full queue; pops never reject.
   assign rejected_in = accept ? (is_push && is_full) : rejected_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rejected_ff <= rejected_in;
   end

   // The response reads the queue as it stands: the state only moves on an
   // accepted request, made only with no beat waiting or as the old beat leaves.
   assign count_ext         = {5'd0, count_ff};
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_empty      = (count_ff == '0);
   assign rsp_head_code     = rsp_is_empty ? 32'sd0 : cell_entry[0].code;
   assign rsp_entry_count   = count_ext[4:0];
   assign rsp_push_rejected = rejected_ff;

   // The fill count never runs past the number of cells.
   `SPQ_ASSERT_IMPLY(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY),
      "fill count exceeds capacity")
   // A response waiting on the output holds the queue still.
   `SPQ_ASSERT_NEXT(a_stall_holds, rsp_valid_ff && !rsp_ready, $stable(count_ff),
      "queue changed while a response beat was stalled")
   // A reported rejection always comes with a full queue.
   `SPQ_ASSERT_IMPLY(a_reject_full, rsp_valid_ff && rejected_ff,
      count_ff == CNT_W'(CAPACITY), "push rejected while queue not full")
   // The two front entries stay in ascending key order.
   `SPQ_ASSERT_IMPLY(a_head_order, count_ff >= CNT_W'(2),
      !(cell_entry[1].price < cell_entry[0].price), "head entries out of order")

endmodule

`default_nettype wire
